### rtl/core/chd_pkg.sv
// Shared types and constants for the compass heading pipeline.
// No dependencies; every other file refers to this package by scoped names.
package chd_pkg;

    localparam int AXIS_W = 16;
    localparam int XY_W = 36;
    localparam int Z_W = 26;
    localparam int ZU_W = 25;
    localparam int FINE_W = 15;
    localparam int DEG_W = 9;
    localparam int TABLE_LEN = 24;
    localparam int ROTATION_STEPS_DEFAULT = 16;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [Z_W:0] FULL_TURN = 27'sd23592960;
    localparam logic [FINE_W:0] FINE_FULL = 16'd23040;
    localparam logic [Z_W-1:0] ROUND_HALF = 26'd512;

    localparam logic [21:0] ATAN_TABLE [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } chd_vec_t;

endpackage

### rtl/core/chd_if.sv
// Request channels of the compass heading block: sample pairs in, headings out.
// Depends on chd_pkg for field widths.
interface chd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [chd_pkg::AXIS_W-1:0]   axis_x;
    logic signed [chd_pkg::AXIS_W-1:0]   axis_y;

    modport source (output valid, output axis_x, output axis_y, input ready);
    modport sink (input valid, input axis_x, input axis_y, output ready);
endinterface

interface chd_out_if;
    logic                          valid;
    logic                          ready;
    logic [chd_pkg::FINE_W-1:0]    heading_fine;
    logic [chd_pkg::DEG_W-1:0]     heading_degrees;

    modport source (output valid, output heading_fine, output heading_degrees, input ready);
    modport sink (input valid, input heading_fine, input heading_degrees, output ready);
endinterface

### rtl/core/compass_heading_from_xy.sv
// Compass heading atan2(y, x) in [0, 360) degrees from a magnetometer sample pair.
// Depends on chd_pkg, chd_if, chd_prerot, chd_rot_stage and chd_fold.
//
// Channel   Direction  Payload
// sample    in         axis_x (s16), axis_y (s16)
// heading   out        heading_fine (u15, 1/64 deg), heading_degrees (u9)
//
// One request enters per cycle when the pipeline is not blocked.
// A request passes through the pre-rotation stage, one stage per
// rotation step, the fold stage and the rounding stage, which is the output register.
// Each stage holds its request while the next one is full, so a stalled result
// frees no data and empty stages still fill behind it.
// Reset clears only the valid bits of the stages.
module compass_heading_from_xy
#(
    parameter int ROTATION_STEPS = chd_pkg::ROTATION_STEPS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    chd_in_if.sink     sample,
    chd_out_if.source  heading
);

    localparam int STEPS_RUN =
        (ROTATION_STEPS < chd_pkg::TABLE_LEN) ? ROTATION_STEPS : chd_pkg::TABLE_LEN;

    logic [STEPS_RUN:0] stg_valid;
    logic [STEPS_RUN:0] stg_ready;
    chd_pkg::chd_vec_t  stg_data [STEPS_RUN+1];

    chd_prerot u_prerot
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (sample.valid),
        .up_ready   (sample.ready),
        .axis_x     (sample.axis_x),
        .axis_y     (sample.axis_y),
        .down_valid (stg_valid[0]),
        .down_ready (stg_ready[0]),
        .down_data  (stg_data[0])
    );

    for (genvar i = 0; i < STEPS_RUN; i++)
    begin : g_rot
        chd_rot_stage
        #(
            .STAGE_INDEX (i)
        )
        u_stage
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stg_valid[i]),
            .up_ready   (stg_ready[i]),
            .up_data    (stg_data[i]),
            .down_valid (stg_valid[i+1]),
            .down_ready (stg_ready[i+1]),
            .down_data  (stg_data[i+1])
        );
    end

    chd_fold u_fold
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (stg_valid[STEPS_RUN]),
        .up_ready        (stg_ready[STEPS_RUN]),
        .up_data         (stg_data[STEPS_RUN]),
        .down_valid      (heading.valid),
        .down_ready      (heading.ready),
        .heading_fine    (heading.heading_fine),
        .heading_degrees (heading.heading_degrees)
    );

    a_fine_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading.valid |-> heading.heading_fine < 15'd23040)
        else $error("heading_fine outside one turn");

    a_degrees_match: assert property (@(posedge clk) disable iff (!rst_n)
        heading.valid |-> heading.heading_degrees == heading.heading_fine[14:6])
        else $error("heading_degrees does not match heading_fine");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !heading.valid |-> stg_ready[STEPS_RUN])
        else $error("fold stage with an empty output refuses a request");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[0] && !stg_ready[0]) |=> stg_valid[0] && $stable(stg_data[0]))
        else $error("stalled pre-rotation stage lost its request");

endmodule

### rtl/core/chd_prerot.sv
// Input stage: quarter-turn pre-rotation into the right half plane and scaling.
// Depends on chd_pkg.
module chd_prerot
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [chd_pkg::AXIS_W-1:0] axis_x,
    input  logic signed [chd_pkg::AXIS_W-1:0] axis_y,
    output logic                              down_valid,
    input  logic                              down_ready,
    output chd_pkg::chd_vec_t                 down_data
);

    logic              valid_reg;
    chd_pkg::chd_vec_t data_reg;
    chd_pkg::chd_vec_t data_next;
    logic signed [chd_pkg::AXIS_W:0] xw;
    logic signed [chd_pkg::AXIS_W:0] yw;
    logic signed [chd_pkg::AXIS_W:0] xr;
    logic signed [chd_pkg::AXIS_W:0] yr;

    assign up_ready = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data = data_reg;

    always_comb
    begin
        xw = {axis_x[chd_pkg::AXIS_W-1], axis_x};
        yw = {axis_y[chd_pkg::AXIS_W-1], axis_y};
        xr = xw;
        yr = yw;
        data_next.z = '0;
        if (axis_x < 0)
        begin
            if (axis_y >= 0)
            begin
                xr = yw;
                yr = -xw;
                data_next.z = chd_pkg::QUARTER_TURN;
            end
            else
            begin
                xr = -yw;
                yr = xw;
                data_next.z = -chd_pkg::QUARTER_TURN;
            end
        end
        data_next.x = {{(chd_pkg::XY_W - chd_pkg::AXIS_W - 17){xr[chd_pkg::AXIS_W]}}, xr, 16'b0};
        data_next.y = {{(chd_pkg::XY_W - chd_pkg::AXIS_W - 17){yr[chd_pkg::AXIS_W]}}, yr, 16'b0};
        data_next.zero = (axis_x == 0) && (axis_y == 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/core/chd_rot_stage.sv
// One vectoring shift-add rotation stage with a fixed shift and arctangent step.
// Depends on chd_pkg.
module chd_rot_stage
#(
    parameter int STAGE_INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  chd_pkg::chd_vec_t up_data,
    output logic              down_valid,
    input  logic              down_ready,
    output chd_pkg::chd_vec_t down_data
);

    localparam logic signed [chd_pkg::Z_W-1:0] ARC =
        signed'(chd_pkg::Z_W'(chd_pkg::ATAN_TABLE[STAGE_INDEX]));

    logic              valid_reg;
    chd_pkg::chd_vec_t data_reg;
    chd_pkg::chd_vec_t data_next;
    logic signed [chd_pkg::XY_W-1:0] dx;
    logic signed [chd_pkg::XY_W-1:0] dy;

    assign up_ready = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data = data_reg;

    always_comb
    begin
        dx = up_data.y >>> STAGE_INDEX;
        dy = up_data.x >>> STAGE_INDEX;
        data_next.zero = up_data.zero;
        if (up_data.y >= 0)
        begin
            data_next.x = up_data.x + dx;
            data_next.y = up_data.y - dy;
            data_next.z = up_data.z + ARC;
        end
        else
        begin
            data_next.x = up_data.x - dx;
            data_next.y = up_data.y + dy;
            data_next.z = up_data.z - ARC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/core/chd_fold.sv
// Output stages: folding into one turn, then rounding to 1/64 degree with wrap.
// Depends on chd_pkg; the second stage is the output register.
module chd_fold
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  chd_pkg::chd_vec_t              up_data,
    output logic                           down_valid,
    input  logic                           down_ready,
    output logic [chd_pkg::FINE_W-1:0]     heading_fine,
    output logic [chd_pkg::DEG_W-1:0]      heading_degrees
);

    logic                           turn_valid_reg;
    logic                           out_valid_reg;
    logic                           turn_ready;
    logic [chd_pkg::ZU_W-1:0]       turn_reg;
    logic [chd_pkg::ZU_W-1:0]       turn_next;
    logic [chd_pkg::FINE_W-1:0]     fine_reg;
    logic [chd_pkg::FINE_W-1:0]     fine_next;
    logic signed [chd_pkg::Z_W:0]   zw;
    logic signed [chd_pkg::Z_W:0]   zf;
    logic [chd_pkg::Z_W-1:0]        rounded;
    logic [chd_pkg::FINE_W:0]       fine_raw;

    assign turn_ready = !out_valid_reg || down_ready;
    assign up_ready = !turn_valid_reg || turn_ready;
    assign down_valid = out_valid_reg;
    assign heading_fine = fine_reg;
    assign heading_degrees = fine_reg[chd_pkg::FINE_W-1:chd_pkg::FINE_W-chd_pkg::DEG_W];

    always_comb
    begin
        zw = {up_data.z[chd_pkg::Z_W-1], up_data.z};
        zf = (zw < 0) ? zw + chd_pkg::FULL_TURN : zw;
        if (up_data.zero || zf < 0)
        begin
            turn_next = '0;
        end
        else
        begin
            turn_next = zf[chd_pkg::ZU_W-1:0];
        end
    end

    always_comb
    begin
        rounded = {1'b0, turn_reg} + chd_pkg::ROUND_HALF;
        fine_raw = rounded[chd_pkg::Z_W-1:10];
        if (fine_raw >= chd_pkg::FINE_FULL)
        begin
            fine_next = chd_pkg::FINE_W'(fine_raw - chd_pkg::FINE_FULL);
        end
        else
        begin
            fine_next = fine_raw[chd_pkg::FINE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                turn_valid_reg <= up_valid;
            end
            if (turn_ready)
            begin
                out_valid_reg <= turn_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            turn_reg <= turn_next;
        end
        if (turn_ready && turn_valid_reg)
        begin
            fine_reg <= fine_next;
        end
    end

endmodule
